// ----- hw/rtl/mbps_pkg.sv -----
// Shared types and constants for the masked byte pattern scanner.
// No dependencies; every RTL file of the scanner imports this package.
package mbps_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned PAT_BYTES  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 48;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO = 2'd0,
    REG_PAT_HI = 2'd1,
    REG_CARE   = 2'd2,
    REG_LEN    = 2'd3
  } cfg_reg_e;

  // Current configuration as seen by the compare logic.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [PAT_BYTES-1:0]  care;
    logic [LEN_W-1:0]      len;
  } cfg_t;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

endpackage

// ----- hw/rtl/masked_byte_pattern_scanner_core.sv -----
// Masked byte pattern scanner: one result per byte. Throughput is one byte per cycle while
// results are taken without stalls; the input register and the result register each
// hold one item, and the result register frees up in the cycle its request is taken.
// Reset (rst_ni, asynchronous, active low) empties both stages and the window, and sets
// the pattern registers and care mask to zero and the pattern length to one.
module masked_byte_pattern_scanner_core import mbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte, [55:8] byte_address
  input  logic                   s_axis_tuser,  // [0] region_start
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [47:0] match_address
  output logic                   m_axis_tuser,  // [0] match_found
  // Configuration writes.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN_BYTES + 1);

  cfg_t                                     cfg;
  logic                                     adv;
  logic                                     stage_valid;
  logic [MAX_PATTERN_BYTES-1:0][DATA_W-1:0] window;
  logic [LenW-1:0]                          fill;
  logic [ADDR_W-1:0]                        stage_addr;

  mbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbps_window #(
    .MaxBytes (MAX_PATTERN_BYTES),
    .LenW     (LenW)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .data_i        (s_axis_tdata[DATA_W-1:0]),
    .addr_i        (s_axis_tdata[DATA_W+ADDR_W-1:DATA_W]),
    .start_i       (s_axis_tuser),
    .adv_i         (adv),
    .stage_valid_o (stage_valid),
    .window_o      (window),
    .fill_o        (fill),
    .addr_o        (stage_addr)
  );

  mbps_match #(
    .MaxBytes (MAX_PATTERN_BYTES),
    .LenW     (LenW)
  ) u_match (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .stage_valid_i (stage_valid),
    .window_i      (window),
    .fill_i        (fill),
    .addr_i        (stage_addr),
    .adv_o         (adv),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .found_o       (m_axis_tuser),
    .match_addr_o  (m_axis_tdata)
  );

  // A result without a match carries a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("non-match result with nonzero address");

  // The input stage is never overwritten while its item cannot move on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && stage_valid |-> adv)
    else $error("input stage accepted while occupied");

  // A request that opens a region restarts the fill count at one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> fill == LenW'(1))
    else $error("fill count not restarted on region start");

  // The fill count never passes the window depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill) <= MAX_PATTERN_BYTES)
    else $error("fill count beyond window depth");

endmodule

// ----- hw/rtl/mbps_cfg_regs.sv -----
// Configuration register file of the pattern scanner.
// Depends on mbps_pkg for the register indexes and the cfg_t struct.
module mbps_cfg_regs import mbps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Decode the register index of a write request.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PAT_LO: cfg_d.pat_lo = cfg_data_i;
        REG_PAT_HI: cfg_d.pat_hi = cfg_data_i;
        REG_CARE:   cfg_d.care   = cfg_data_i[PAT_BYTES-1:0];
        REG_LEN:    cfg_d.len    = cfg_data_i[LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat_lo <= '0;
      cfg_q.pat_hi <= '0;
      cfg_q.care   <= '0;
      cfg_q.len    <= LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/mbps_window.sv -----
// Input stage of the pattern scanner: byte window, fill count and address register.
// Depends on mbps_pkg for the field widths.
module mbps_window import mbps_pkg::*; #(
  parameter int unsigned MaxBytes = 16,
  parameter int unsigned LenW     = $clog2(MaxBytes + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [DATA_W-1:0]              data_i,
  input  logic [ADDR_W-1:0]              addr_i,
  input  logic                           start_i,
  input  logic                           adv_i,
  output logic                           stage_valid_o,
  output logic [MaxBytes-1:0][DATA_W-1:0] window_o,
  output logic [LenW-1:0]                fill_o,
  output logic [ADDR_W-1:0]              addr_o
);

  localparam logic [LenW-1:0] FillMax = LenW'(MaxBytes);
  localparam logic [LenW-1:0] FillOne = LenW'(1);

  logic [MaxBytes-1:0][DATA_W-1:0] win_q, win_d;
  logic [LenW-1:0]                 fill_q, fill_d;
  logic [ADDR_W-1:0]               addr_q;
  logic                            valid_q, valid_d;
  logic                            accept;

  // The stage takes a new request when empty or when its content moves on.
  assign in_ready_o = !valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;

  // Shift the new byte into the window; entry 0 is the newest byte.
  always_comb begin
    win_d = win_q;
    if (accept) begin
      for (int k = MaxBytes - 1; k > 0; k--) begin
        win_d[k] = win_q[k-1];
      end
      win_d[0] = data_i;
    end
  end

  // Fill count restarts on a new region and saturates at the window depth.
  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      if (start_i) begin
        fill_d = FillOne;
      end else if (fill_q != FillMax) begin
        fill_d = fill_q + FillOne;
      end
    end
  end

  // Stage occupancy.
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      win_q   <= win_d;
      fill_q  <= fill_d;
      valid_q <= valid_d;
    end
  end

  // The address is payload only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= addr_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign window_o      = win_q;
  assign fill_o        = fill_q;
  assign addr_o        = addr_q;

endmodule

// ----- hw/rtl/mbps_match.sv -----
// Masked compare of the byte window against the pattern, with the result register.
// Depends on mbps_pkg for the field widths and the cfg_t struct.
module mbps_match import mbps_pkg::*; #(
  parameter int unsigned MaxBytes = 16,
  parameter int unsigned LenW     = $clog2(MaxBytes + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfg_t                            cfg_i,
  input  logic                            stage_valid_i,
  input  logic [MaxBytes-1:0][DATA_W-1:0] window_i,
  input  logic [LenW-1:0]                 fill_i,
  input  logic [ADDR_W-1:0]               addr_i,
  output logic                            adv_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic [ADDR_W-1:0]               match_addr_o
);

  logic [PAT_BYTES-1:0][DATA_W-1:0] pat_arr;
  logic [LenW-1:0]                  eff_len;
  logic [MaxBytes-1:0]              mismatch;
  logic                             hit;
  logic [ADDR_W-1:0]                start_addr;
  logic                             valid_q, valid_d;
  logic                             found_q;
  logic [ADDR_W-1:0]                addr_q;

  assign pat_arr = {cfg_i.pat_hi, cfg_i.pat_lo};

  // Length in use: zero acts as one, anything beyond the window acts as full depth.
  always_comb begin
    if (cfg_i.len == '0) begin
      eff_len = LenW'(1);
    end else if (int'(cfg_i.len) > MaxBytes) begin
      eff_len = LenW'(MaxBytes);
    end else begin
      eff_len = LenW'(cfg_i.len);
    end
  end

  // Window entry j lines up with pattern byte len-1-j; bytes past sixteen are wildcards.
  always_comb begin
    int k;
    for (int j = 0; j < MaxBytes; j++) begin
      k = int'(eff_len) - 1 - j;
      mismatch[j] = 1'b0;
      if (k >= 0 && k < PAT_BYTES) begin
        mismatch[j] = cfg_i.care[k[3:0]] && (window_i[j] != pat_arr[k[3:0]]);
      end
    end
  end

  assign hit        = (fill_i >= eff_len) && (mismatch == '0);
  assign start_addr = addr_i - ADDR_W'(eff_len - LenW'(1));

  // Result register: loads when empty or when its content is taken.
  assign adv_o = stage_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      found_q <= hit;
      addr_q  <= hit ? start_addr : '0;
    end
  end

  assign out_valid_o  = valid_q;
  assign found_o      = found_q;
  assign match_addr_o = addr_q;

endmodule

// ----- tb/mbps_scan_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the masked byte pattern scanner: snoops the byte, result and register channels.
// Depends on mbps_pkg for widths and register indexes; predicts every result and compares it.
module mbps_scan_checker import mbps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,    // [7:0] data_byte, [55:8] byte_address
  input  logic                   in_user_i,    // [0] region_start
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [OUT_TDATA_W-1:0] out_data_i,   // [47:0] match_address
  input  logic                   out_user_i,   // [0] match_found
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     errors_o,
  output int                     results_o,
  output int                     matches_o,
  output int                     pending_o
);

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_hit_t;

  scan_hit_t expected_hits[$];

  // Shadow copy of the registers and the byte window.
  logic [CFG_DATA_W-1:0] pat_lo_q;
  logic [CFG_DATA_W-1:0] pat_hi_q;
  logic [PAT_BYTES-1:0]  care_q;
  logic [LEN_W-1:0]      len_q;
  logic [DATA_W-1:0]     win_q [PAT_BYTES];
  int unsigned           fill_q;
  int                    err_cnt;
  int                    res_cnt;
  int                    hit_cnt;

  // Shifts one byte into the window and tests the window that ends at it.
  function automatic scan_hit_t scan_window(input logic [DATA_W-1:0] d,
                                            input logic [ADDR_W-1:0] a, input logic st);
    int unsigned               eff;
    logic [2*CFG_DATA_W-1:0]   pat;
    scan_hit_t                 r;
    eff = (len_q == 0) ? 1 : ((len_q > PAT_BYTES) ? PAT_BYTES : len_q);
    pat = {pat_hi_q, pat_lo_q};
    if (st) fill_q = 0;
    for (int k = PAT_BYTES - 1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = d;
    if (fill_q < PAT_BYTES) fill_q++;
    r.found = (fill_q >= eff);
    for (int k = 0; k < eff; k++) begin
      if (care_q[k] && win_q[eff-1-k] !== pat[8*k +: 8]) r.found = 1'b0;
    end
    r.addr = r.found ? (a - ADDR_W'(eff - 1)) : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_hit_t exp_hit;
    if (!rst_ni) begin
      pat_lo_q = '0;
      pat_hi_q = '0;
      care_q   = '0;
      len_q    = LEN_RESET;
      for (int k = 0; k < PAT_BYTES; k++) win_q[k] = '0;
      fill_q   = 0;
      err_cnt  = 0;
      res_cnt  = 0;
      hit_cnt  = 0;
      expected_hits.delete();
      errors_o  <= 0;
      results_o <= 0;
      matches_o <= 0;
      pending_o <= 0;
    end else begin
      // Register writes only happen while idle, so they apply before the next byte.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_PAT_LO: pat_lo_q = cfg_data_i;
          REG_PAT_HI: pat_hi_q = cfg_data_i;
          REG_CARE:   care_q   = cfg_data_i[PAT_BYTES-1:0];
          REG_LEN:    len_q    = cfg_data_i[LEN_W-1:0];
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_hits.insert(expected_hits.size(),
                             scan_window(in_data_i[DATA_W-1:0],
                                         in_data_i[DATA_W +: ADDR_W], in_user_i));
      end
      // Each result is compared with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        res_cnt++;
        if (out_user_i === 1'b1) hit_cnt++;
        if (expected_hits.size() == 0) begin
          $error("unexpected result: match_found %0b match_address %h", out_user_i,
                 out_data_i[ADDR_W-1:0]);
          err_cnt++;
        end else begin
          exp_hit = expected_hits.pop_front();
          if (out_user_i !== exp_hit.found) begin
            $error("match_found: expected %0b, actual %0b", exp_hit.found, out_user_i);
            err_cnt++;
          end
          if (out_data_i[ADDR_W-1:0] !== exp_hit.addr) begin
            $error("match_address: expected %h, actual %h", exp_hit.addr,
                   out_data_i[ADDR_W-1:0]);
            err_cnt++;
          end
        end
      end
      errors_o  <= err_cnt;
      results_o <= res_cnt;
      matches_o <= hit_cnt;
      pending_o <= expected_hits.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the scanner testbench: clock, reset, byte stimulus, register writes and the verdict.
// Depends on mbps_pkg, masked_byte_pattern_scanner_core and mbps_scan_checker.
module tb_top;
  import mbps_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 103;

  typedef struct {
    logic [DATA_W-1:0] d;
    logic              st;
  } planned_byte_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int chk_errors;
  int chk_results;
  int chk_matches;
  int chk_pending;

  int sent_cnt;
  int settings_cnt;
  logic hold_req;

  // Testbench copy of the registers, used only to shape the stimulus.
  logic [CFG_DATA_W-1:0] tb_pat_lo;
  logic [CFG_DATA_W-1:0] tb_pat_hi;
  logic [PAT_BYTES-1:0]  tb_care;
  int unsigned           tb_eff;

  always #2 clk_i = ~clk_i;

  masked_byte_pattern_scanner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  mbps_scan_checker scan_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (chk_errors),
    .results_o   (chk_results),
    .matches_o   (chk_matches),
    .pending_o   (chk_pending)
  );

  function automatic logic [DATA_W-1:0] pat_byte_at(input int unsigned k);
    logic [2*CFG_DATA_W-1:0] pat_all;
    pat_all = {tb_pat_hi, tb_pat_lo};
    return pat_all[8*k +: 8];
  endfunction

  // Offers one byte request and holds it until the scanner takes it.
  task automatic send_byte(input logic [DATA_W-1:0] d, input logic [ADDR_W-1:0] a,
                           input logic st);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {a, d};
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
  endtask

  // Stops offering bytes and waits until every predicted result has come back.
  // The wait always passes a clock edge, so the next request is driven in a later time step.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (chk_results != sent_cnt);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes all four registers once the scanner is idle.
  task automatic set_config(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                            input logic [PAT_BYTES-1:0] care, input logic [LEN_W-1:0] len);
    wait_drained();
    repeat (4) @(posedge clk_i);
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    write_reg(REG_CARE, CFG_DATA_W'(care));
    write_reg(REG_LEN, CFG_DATA_W'(len));
    cfg_valid_i <= 1'b0;
    tb_pat_lo = lo;
    tb_pat_hi = hi;
    tb_care   = care;
    tb_eff    = (len == 0) ? 1 : ((len > PAT_BYTES) ? PAT_BYTES : len);
    settings_cnt++;
  endtask

  // Receiver: changes its stall pattern now and then, and holds off once for a long stretch.
  initial begin : rx_proc
    int   mode;
    int   left;
    int   hold_left;
    int   cyc;
    bit   hold_taken;
    mode = 0;
    left = 0;
    hold_left = 0;
    cyc = 0;
    hold_taken = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 9) < 2);
          default: m_axis_tready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run if no channel moves a request for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    planned_byte_t         planned_bytes[$];
    planned_byte_t         pb;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [PAT_BYTES-1:0]  care;
    logic [LEN_W-1:0]      len;
    logic [ADDR_W-1:0]     cur_addr;
    logic [DATA_W-1:0]     d;
    logic                  st;
    int                    burst_left;
    int                    gap;
    int                    tb_errors;
    bit                    no_gap;
    int                    pos;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_PAT_LO;
    cfg_data_i    = '0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    sent_cnt      = 0;
    settings_cnt  = 0;
    tb_errors     = 0;
    burst_left    = 0;
    cur_addr      = '0;
    tb_pat_lo     = '0;
    tb_pat_hi     = '0;
    tb_care       = '0;
    tb_eff        = 1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: length one, all wildcards, so every byte hits at its own address.
    // The first byte has no region flag, since reset already empties the window.
    send_byte(8'h00, 48'h0000_0000_0000, 1'b0);
    send_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_byte("x", 48'h0000_0000_0001, 1'b1);
    send_byte("?", 48'h8000_0000_0000, 1'b0);

    // Three-byte pattern; the start address wraps below zero.
    set_config(64'h0000_0000_0043_4241, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0007, 5'd3);
    send_byte("A", 48'hFFFF_FFFF_FFFE, 1'b1);
    send_byte("B", 48'hFFFF_FFFF_FFFF, 1'b0);
    send_byte("C", 48'h0000_0000_0000, 1'b0);
    // A region boundary inside the pattern leaves only a partial window.
    send_byte("A", 48'h0000_0000_0100, 1'b1);
    send_byte("B", 48'h0000_0000_0101, 1'b0);
    send_byte("C", 48'h0000_0000_0200, 1'b1);

    // Middle byte as a wildcard.
    set_config(64'h0000_0000_0043_4241, 64'h0, 16'h0005, 5'd3);
    send_byte("A", 48'h0000_0000_0010, 1'b1);
    send_byte("?", 48'h0000_0000_0011, 1'b0);
    send_byte("C", 48'h0000_0000_0012, 1'b0);

    // A length of zero behaves like one.
    set_config(64'h0000_0000_0000_00FF, 64'h0, 16'hFFFF, 5'd0);
    send_byte(8'hFF, 48'h0000_1234_5678, 1'b0);
    send_byte(8'h00, 48'h0000_1234_5679, 1'b0);

    // Random phases: mostly planted patterns with random content, some broken, some noise.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          lo = '1; hi = '1; care = '1; len = 5'd31;
        end
        1: begin
          lo = '0; hi = '0; care = '0; len = 5'd0;
        end
        2: begin
          lo = {$urandom, $urandom}; hi = {$urandom, $urandom};
          care = 16'($urandom); len = 5'd16;
        end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
          case ($urandom_range(0, 2))
            0:       care = '1;
            1:       care = 16'($urandom);
            default: care = 16'($urandom & $urandom);
          endcase
          len = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 6)) : 5'($urandom_range(0, 31));
        end
      endcase
      set_config(lo, hi, care, len);
      planned_bytes.delete();
      no_gap = (ph == 3) || (ph == 5);
      if (ph == 3) hold_req <= 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Sender bursts with random gaps between them.
        if (!no_gap) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
              s_axis_tvalid <= 1'b0;
              repeat (gap) @(posedge clk_i);
            end
          end
          burst_left--;
        end
        // Once, midway through phase 6, let every result come back before going on.
        if (ph == 6 && n == PHASE_ITEMS / 2) wait_drained();

        if (planned_bytes.size() == 0 && $urandom_range(0, 99) < 40) begin
          for (int k = 0; k < tb_eff; k++) begin
            pb.d  = tb_care[k] ? pat_byte_at(k) : 8'($urandom);
            pb.st = (k == 0) && ($urandom_range(0, 99) < 20);
            planned_bytes.insert(planned_bytes.size(), pb);
          end
          // Broken sequences: a flipped bit or a region boundary partway through.
          if ($urandom_range(0, 99) < 15) begin
            pos = $urandom_range(0, tb_eff - 1);
            planned_bytes[pos].d[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
          end
          if (tb_eff > 1 && $urandom_range(0, 99) < 8) begin
            planned_bytes[$urandom_range(1, tb_eff - 1)].st = 1'b1;
          end
        end
        if (planned_bytes.size() > 0) begin
          pb = planned_bytes.pop_front();
          d  = pb.d;
          st = pb.st;
        end else begin
          d  = ($urandom_range(0, 99) < 30) ? pat_byte_at($urandom_range(0, PAT_BYTES - 1))
                                            : 8'($urandom);
          st = ($urandom_range(0, 99) < 3);
        end
        // A new region jumps to a fresh base address, sometimes just below the top.
        if (st) begin
          if ($urandom_range(0, 9) == 0)
            cur_addr = '1 - ADDR_W'($urandom_range(0, 20));
          else
            cur_addr = ADDR_W'({$urandom, $urandom});
        end else begin
          cur_addr = cur_addr + 1'b1;
        end
        send_byte(d, cur_addr, st);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (chk_pending != 0) begin
      $error("%0d predicted results never arrived", chk_pending);
      tb_errors++;
    end
    $display("Summary: %0d bytes scanned under %0d register settings, %0d matches reported,",
             sent_cnt, settings_cnt, chk_matches);
    $display("Summary: region breaks, wildcards, address wrap and a long output stall included.");
    if (chk_errors + tb_errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
